@@ rtl/srr_pkg.sv @@
`default_nettype none

package srr_pkg;

    localparam int SEQ_IN_BITS = 4;
    localparam int ACK_BITS    = 4;
    localparam int WLEN_BITS   = 4;

    localparam logic [WLEN_BITS-1:0] WLEN_RESET = 4'd4;

    localparam logic KIND_DELIVER = 1'b0;
    localparam logic KIND_ACK     = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_DRAIN = 2'b10
    } state_t;

    typedef struct packed {
        logic shift;
        logic wr;
    } cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/srr_in_if.sv @@
`default_nettype none

interface srr_in_if #(
    parameter int PAYLOAD_BITS = 32
);
    logic                            valid;
    logic                            ready;
    logic [srr_pkg::SEQ_IN_BITS-1:0] seq_num;
    logic                            checksum_ok;
    logic [PAYLOAD_BITS-1:0]         payload;

    modport source (output valid, output seq_num, output checksum_ok, output payload,
                    input ready);
    modport sink   (input valid, input seq_num, input checksum_ok, input payload,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/srr_out_if.sv @@
`default_nettype none

interface srr_out_if #(
    parameter int PAYLOAD_BITS = 32
);
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [PAYLOAD_BITS-1:0]      data;
    logic [srr_pkg::ACK_BITS-1:0] ack_num;
    logic                         last;

    modport source (output valid, output kind, output data, output ack_num, output last,
                    input ready);
    modport sink   (input valid, input kind, input data, input ack_num, input last,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/srr_cell.sv @@
`default_nettype none

module srr_cell #(
    parameter int PAYLOAD_BITS = 32
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire srr_pkg::cell_ctrl_t ctrl,
    input  wire [PAYLOAD_BITS-1:0]   wr_payload,
    input  wire                      nb_valid,
    input  wire [PAYLOAD_BITS-1:0]   nb_payload,
    output logic                     valid,
    output logic [PAYLOAD_BITS-1:0]  payload
);

    logic                    valid_reg;
    logic                    valid_next;
    logic [PAYLOAD_BITS-1:0] payload_reg;
    logic [PAYLOAD_BITS-1:0] payload_next;

    always_comb
    begin
        valid_next   = valid_reg;
        payload_next = payload_reg;
        if (ctrl.shift)
        begin
            valid_next   = nb_valid;
            payload_next = nb_payload;
        end
        else if (ctrl.wr)
        begin
            valid_next   = 1'b1;
            payload_next = wr_payload;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        payload_reg <= payload_next;
    end

    assign valid   = valid_reg;
    assign payload = payload_reg;

endmodule

`default_nettype wire

@@ rtl/selective_repeat_receiver.sv @@
//  channel | dir | fields                                  | handshake
//  pkt     | in  | seq_num, checksum_ok, payload           | valid/ready
//  res     | out | kind, data, ack_num, last               | valid/ready
//  cfg     | in  | cfg_wdata (window_length)               | cfg_we
//
//  Corrupt, buffered or dropped packet: the ACK is registered at once.
//  In-order packet: n deliveries (n up to MAX_WINDOW), then the ACK; the
//  slot chain shifts by one cell per delivery.
//  Reset clears the slot valid bits and the window state; no clearing pass.
//  A stall on res holds the drain; pkt is taken only while no result waits.
`default_nettype none

module selective_repeat_receiver #(
    parameter int SEQ_SPACE    = 16,
    parameter int MAX_WINDOW   = 8,
    parameter int INITIAL_SEQ  = 0,
    parameter int PAYLOAD_BITS = 32
) (
    input  wire                             clk,
    input  wire                             rst_n,
    srr_in_if.sink                          pkt,
    srr_out_if.source                       res,
    input  wire                             cfg_we,
    input  wire [srr_pkg::WLEN_BITS-1:0]    cfg_wdata
);

    localparam int SW     = (SEQ_SPACE > 2) ? $clog2(SEQ_SPACE) : 1;
    localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
    localparam int BASE_RST = INITIAL_SEQ % SEQ_SPACE;
    localparam int ACK_RST  = (BASE_RST + SEQ_SPACE - 1) % SEQ_SPACE;

    srr_pkg::state_t state_reg, state_next;

    logic [SW-1:0]                 base_reg, base_next;
    logic [SW-1:0]                 prior_ack_reg, prior_ack_next;
    logic [SW-1:0]                 ack_seq_reg, ack_seq_next;
    logic [srr_pkg::WLEN_BITS-1:0] wlen_reg;

    logic                           res_valid_reg, res_valid_next;
    logic                           res_kind_reg, res_kind_next;
    logic [PAYLOAD_BITS-1:0]        res_data_reg, res_data_next;
    logic [srr_pkg::ACK_BITS-1:0]   res_ack_reg, res_ack_next;
    logic                           res_last_reg, res_last_next;

    srr_pkg::cell_ctrl_t            ctrl [MAX_WINDOW];
    logic                           cell_valid [MAX_WINDOW];
    logic [PAYLOAD_BITS-1:0]        cell_payload [MAX_WINDOW];

    logic [8:0]       seq_full;
    logic [SW-1:0]    seq_red;
    logic [SW:0]      diff_raw;
    logic [SW-1:0]    diff;
    logic [WIN_W-1:0] win_eff;
    logic             in_window;
    logic             out_free;
    logic             accept;

    // sequence number reduced modulo the space
    always_comb
    begin
        seq_full = 9'(pkt.seq_num);
        for (int i = 0; i < 8; i++)
        begin
            if (seq_full >= 9'(SEQ_SPACE))
            begin
                seq_full = seq_full - 9'(SEQ_SPACE);
            end
        end
    end

    assign seq_red  = SW'(seq_full);
    assign diff_raw = {1'b0, seq_red} - {1'b0, base_reg};
    assign diff     = diff_raw[SW] ? SW'(diff_raw + (SW+1)'(SEQ_SPACE)) : diff_raw[SW-1:0];

    always_comb
    begin
        if (wlen_reg == '0)
        begin
            win_eff = WIN_W'(1);
        end
        else if (32'(wlen_reg) > MAX_WINDOW)
        begin
            win_eff = WIN_W'(MAX_WINDOW);
        end
        else
        begin
            win_eff = WIN_W'(wlen_reg);
        end
    end

    assign in_window = 32'(diff) < 32'(win_eff);
    assign out_free  = !res_valid_reg || res.ready;
    assign pkt.ready = (state_reg == srr_pkg::S_IDLE) && out_free;
    assign accept    = pkt.valid && pkt.ready;

    always_comb
    begin
        state_next     = state_reg;
        base_next      = base_reg;
        prior_ack_next = prior_ack_reg;
        ack_seq_next   = ack_seq_reg;
        res_valid_next = res_valid_reg && !res.ready;
        res_kind_next  = res_kind_reg;
        res_data_next  = res_data_reg;
        res_ack_next   = res_ack_reg;
        res_last_next  = res_last_reg;
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            ctrl[i] = '0;
        end

        case (state_reg)
            srr_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (!pkt.checksum_ok)
                    begin
                        res_valid_next = 1'b1;
                        res_kind_next  = srr_pkg::KIND_ACK;
                        res_data_next  = '0;
                        res_ack_next   = srr_pkg::ACK_BITS'(prior_ack_reg);
                        res_last_next  = 1'b1;
                    end
                    else
                    begin
                        prior_ack_next = seq_red;
                        ack_seq_next   = seq_red;
                        if (diff == '0)
                        begin
                            ctrl[0].wr = 1'b1;
                            state_next = srr_pkg::S_DRAIN;
                        end
                        else
                        begin
                            for (int i = 0; i < MAX_WINDOW; i++)
                            begin
                                ctrl[i].wr = in_window && (32'(diff) == i);
                            end
                            res_valid_next = 1'b1;
                            res_kind_next  = srr_pkg::KIND_ACK;
                            res_data_next  = '0;
                            res_ack_next   = srr_pkg::ACK_BITS'(seq_red);
                            res_last_next  = 1'b1;
                        end
                    end
                end
            end
            srr_pkg::S_DRAIN:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    if (cell_valid[0])
                    begin
                        res_kind_next = srr_pkg::KIND_DELIVER;
                        res_data_next = cell_payload[0];
                        res_ack_next  = '0;
                        res_last_next = 1'b0;
                        for (int i = 0; i < MAX_WINDOW; i++)
                        begin
                            ctrl[i].shift = 1'b1;
                        end
                        base_next = (base_reg == SW'(SEQ_SPACE - 1)) ? '0 : base_reg + 1'b1;
                    end
                    else
                    begin
                        res_kind_next = srr_pkg::KIND_ACK;
                        res_data_next = '0;
                        res_ack_next  = srr_pkg::ACK_BITS'(ack_seq_reg);
                        res_last_next = 1'b1;
                        state_next    = srr_pkg::S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = srr_pkg::S_IDLE;
            end
        endcase
    end

    generate
        for (genvar g = 0; g < MAX_WINDOW; g++)
        begin : g_cell
            logic                    nb_valid;
            logic [PAYLOAD_BITS-1:0] nb_payload;

            if (g == MAX_WINDOW - 1)
            begin : g_tail
                assign nb_valid   = 1'b0;
                assign nb_payload = '0;
            end
            else
            begin : g_link
                assign nb_valid   = cell_valid[g+1];
                assign nb_payload = cell_payload[g+1];
            end

            srr_cell #(
                .PAYLOAD_BITS (PAYLOAD_BITS)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl[g]),
                .wr_payload (pkt.payload),
                .nb_valid   (nb_valid),
                .nb_payload (nb_payload),
                .valid      (cell_valid[g]),
                .payload    (cell_payload[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= srr_pkg::S_IDLE;
            base_reg      <= SW'(BASE_RST);
            prior_ack_reg <= SW'(ACK_RST);
            ack_seq_reg   <= '0;
            wlen_reg      <= srr_pkg::WLEN_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            prior_ack_reg <= prior_ack_next;
            ack_seq_reg   <= ack_seq_next;
            res_valid_reg <= res_valid_next;
            if (cfg_we)
            begin
                wlen_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_kind_reg <= res_kind_next;
        res_data_reg <= res_data_next;
        res_ack_reg  <= res_ack_next;
        res_last_reg <= res_last_next;
    end

    assign res.valid   = res_valid_reg;
    assign res.kind    = res_kind_reg;
    assign res.data    = res_data_reg;
    assign res.ack_num = res_ack_reg;
    assign res.last    = res_last_reg;

endmodule

`default_nettype wire

@@ rtl/srr_checker.sv @@
`default_nettype none

module srr_checker #(
    parameter int PAYLOAD_BITS = 32
) (
    input wire                          clk,
    input wire                          rst_n,
    input wire                          pkt_valid,
    input wire                          pkt_ready,
    input wire                          pkt_checksum_ok,
    input wire                          res_valid,
    input wire                          res_ready,
    input wire                          res_kind,
    input wire [PAYLOAD_BITS-1:0]       res_data,
    input wire [srr_pkg::ACK_BITS-1:0]  res_ack_num,
    input wire                          res_last
);

    // stalled transaction holds its contents
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_kind) && $stable(res_data)
            && $stable(res_ack_num) && $stable(res_last))
        else $error("result changed while stalled");

    a_deliver_fmt: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_kind == srr_pkg::KIND_DELIVER) |-> !res_last && (res_ack_num == '0))
        else $error("delivery marked last or carries an ACK number");

    a_ack_fmt: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_kind == srr_pkg::KIND_ACK) |-> res_last && (res_data == '0))
        else $error("ACK not last or carries data");

    a_no_pkt_over_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_valid && pkt_ready && res_valid |-> res_ready)
        else $error("packet taken while a result waits");

    a_corrupt_ack: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_valid && pkt_ready && !pkt_checksum_ok |=>
            res_valid && (res_kind == srr_pkg::KIND_ACK) && res_last)
        else $error("corrupt packet not answered by an ACK");

endmodule

bind selective_repeat_receiver srr_checker #(
    .PAYLOAD_BITS (PAYLOAD_BITS)
) u_srr_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .pkt_valid       (pkt.valid),
    .pkt_ready       (pkt.ready),
    .pkt_checksum_ok (pkt.checksum_ok),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .res_kind        (res.kind),
    .res_data        (res.data),
    .res_ack_num     (res.ack_num),
    .res_last        (res.last)
);

`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    localparam int PAY_W     = 32;
    localparam int WIN_SLOTS = 8;
    localparam int DUE_DEPTH = 32;

    typedef struct {
        logic             kind;
        logic [PAY_W-1:0] data;
        logic [3:0]       ack_num;
        logic             last;
    } rx_out_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [srr_pkg::WLEN_BITS-1:0] cfg_wdata;

    srr_in_if  #(.PAYLOAD_BITS(PAY_W)) pkt_if ();
    srr_out_if #(.PAYLOAD_BITS(PAY_W)) res_if ();

    selective_repeat_receiver #(
        .SEQ_SPACE    (16),
        .MAX_WINDOW   (WIN_SLOTS),
        .INITIAL_SEQ  (0),
        .PAYLOAD_BITS (PAY_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt       (pkt_if),
        .res       (res_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    rx_out_t                       due_buf[DUE_DEPTH];
    int                            due_wr = 0;
    int                            due_rd = 0;
    logic [3:0]                    rx_base;
    logic [3:0]                    rx_last_ack;
    logic                          rx_slot_vld[WIN_SLOTS];
    logic [PAY_W-1:0]              rx_slot_pay[WIN_SLOTS];
    logic [srr_pkg::WLEN_BITS-1:0] rx_wlen;

    int  mismatches = 0;
    int  packets_sent = 0;
    int  corrupt_sent = 0;
    int  deliveries_seen = 0;
    int  acks_seen = 0;
    bit  src_idle_on = 1'b0;
    bit  sink_idle_on = 1'b0;

    function automatic int pick_gap(input bit enabled);
        int r;
        if (!enabled)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int effective_window(input logic [srr_pkg::WLEN_BITS-1:0] wlen);
        if (wlen == 0)
            return 1;
        if (wlen > WIN_SLOTS)
            return WIN_SLOTS;
        return int'(wlen);
    endfunction

    task automatic push_result(input logic kind, input logic [PAY_W-1:0] data,
                               input logic [3:0] ack_num, input logic last);
        rx_out_t r;
        r.kind    = kind;
        r.data    = data;
        r.ack_num = ack_num;
        r.last    = last;
        due_buf[5'(due_wr)] = r;
        due_wr++;
    endtask

    task automatic window_update(input logic [3:0] seq, input logic ok,
                                 input logic [PAY_W-1:0] pay);
        logic [3:0] diff;
        int         win;
        if (!ok)
        begin
            push_result(srr_pkg::KIND_ACK, '0, rx_last_ack, 1'b1);
            return;
        end
        win  = effective_window(rx_wlen);
        diff = seq - rx_base;
        if (diff == 0)
        begin
            rx_slot_pay[0] = pay;
            rx_slot_vld[0] = 1'b1;
            while (rx_slot_vld[0])
            begin
                push_result(srr_pkg::KIND_DELIVER, rx_slot_pay[0], 4'd0, 1'b0);
                for (int i = 0; i < WIN_SLOTS - 1; i++)
                begin
                    rx_slot_vld[i] = rx_slot_vld[i+1];
                    rx_slot_pay[i] = rx_slot_pay[i+1];
                end
                rx_slot_vld[WIN_SLOTS-1] = 1'b0;
                rx_slot_pay[WIN_SLOTS-1] = '0;
                rx_base = rx_base + 4'd1;
            end
        end
        else if (diff < win)
        begin
            rx_slot_pay[diff[2:0]] = pay;
            rx_slot_vld[diff[2:0]] = 1'b1;
        end
        rx_last_ack = seq;
        push_result(srr_pkg::KIND_ACK, '0, seq, 1'b1);
    endtask

    task automatic send_packet(input logic [3:0] seq, input logic ok,
                               input logic [PAY_W-1:0] pay);
        int gap;
        gap = pick_gap(src_idle_on);
        if (gap > 0)
        begin
            pkt_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pkt_if.valid       <= 1'b1;
        pkt_if.seq_num     <= seq;
        pkt_if.checksum_ok <= ok;
        pkt_if.payload     <= pay;
        @(posedge clk);
        while (!pkt_if.ready)
            @(posedge clk);
        window_update(seq, ok, pay);
        packets_sent++;
        if (!ok)
            corrupt_sent++;
    endtask

    task automatic wait_idle();
        pkt_if.valid <= 1'b0;
        while (due_wr != due_rd)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_window(input logic [srr_pkg::WLEN_BITS-1:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        rx_wlen = value;
    endtask

    task automatic test_directed_core();
        logic [3:0] b;
        send_packet(4'd7, 1'b0, 32'hFFFF_FFFF);
        send_packet(4'd0, 1'b1, 32'h0000_0000);
        b = rx_base;
        send_packet(b + 4'd1, 1'b1, 32'hFFFF_FFFF);
        send_packet(b + 4'd2, 1'b1, 32'hA5A5_5A5A);
        send_packet(b, 1'b1, 32'h5A5A_A5A5);
        b = rx_base;
        send_packet(b + 4'd1, 1'b1, 32'h1111_1111);
        send_packet(b + 4'd1, 1'b1, 32'h2222_2222);
        send_packet(b, 1'b1, 32'h3333_3333);
        send_packet(rx_base - 4'd1, 1'b1, 32'hDEAD_BEEF);
        send_packet(rx_base + 4'd4, 1'b1, 32'hCAFE_F00D);
    endtask

    task automatic test_window_sizes();
        logic [3:0] b;
        write_window(4'd8);
        b = rx_base;
        for (int k = 7; k >= 1; k--)
            send_packet(b + 4'(k), 1'b1, $urandom);
        send_packet(b, 1'b1, $urandom);
        write_window(4'd0);
        b = rx_base;
        send_packet(b + 4'd1, 1'b1, $urandom);
        send_packet(b, 1'b1, $urandom);
        write_window(4'd15);
        b = rx_base;
        send_packet(b + 4'd7, 1'b1, $urandom);
        send_packet(b + 4'd8, 1'b1, $urandom);
        write_window(4'd8);
        b = rx_base;
        send_packet(b + 4'd2, 1'b1, $urandom);
        write_window(4'd1);
        send_packet(b + 4'd1, 1'b1, $urandom);
        send_packet(b, 1'b1, $urandom);
        send_packet(b + 4'd1, 1'b1, $urandom);
    endtask

    task automatic test_random_traffic();
        logic [srr_pkg::WLEN_BITS-1:0] settings[7];
        logic [3:0] seq;
        logic       ok;
        int         win;
        int         r;
        settings = '{4'd1, 4'd8, 4'd3, 4'd0, 4'd15, 4'd5, 4'd4};
        for (int p = 0; p < 7; p++)
        begin
            write_window(p == 6 ? 4'($urandom_range(0, 15)) : settings[p]);
            src_idle_on  = (p % 3) != 0;
            sink_idle_on = (p % 3) != 0;
            win = effective_window(rx_wlen);
            for (int n = 0; n < 21; n++)
            begin
                if ($urandom_range(0, 19) == 0)
                    wait_idle();
                r  = $urandom_range(0, 99);
                ok = 1'b1;
                if (r < 10)
                begin
                    ok  = 1'b0;
                    seq = 4'($urandom);
                end
                else if (r < 35)
                    seq = rx_base;
                else if (r < 80)
                    seq = rx_base + 4'($urandom_range(1, win > 1 ? win - 1 : 1));
                else
                    seq = 4'($urandom);
                send_packet(seq, ok, $urandom);
            end
        end
    endtask

    initial
    begin
        int hold;
        hold = 0;
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                res_if.ready <= 1'b0;
                hold--;
            end
            else
            begin
                res_if.ready <= 1'b1;
                hold = pick_gap(sink_idle_on);
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        rx_out_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (due_wr == due_rd)
            begin
                $display("%0t: unexpected result kind=%0d data=%h ack=%0d last=%0d",
                         $time, res_if.kind, res_if.data, res_if.ack_num, res_if.last);
                mismatches++;
            end
            else
            begin
                want = due_buf[5'(due_rd)];
                due_rd++;
                if (res_if.kind !== want.kind || res_if.data !== want.data ||
                    res_if.ack_num !== want.ack_num || res_if.last !== want.last)
                begin
                    $display("%0t: exp k=%0d d=%h a=%0d l=%0d got k=%0d d=%h a=%0d l=%0d",
                             $time, want.kind, want.data, want.ack_num, want.last,
                             res_if.kind, res_if.data, res_if.ack_num, res_if.last);
                    mismatches++;
                end
                if (want.kind == srr_pkg::KIND_ACK)
                    acks_seen++;
                else
                    deliveries_seen++;
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("timeout with %0d results outstanding", due_wr - due_rd);
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_wdata          <= '0;
        pkt_if.valid       <= 1'b0;
        pkt_if.seq_num     <= '0;
        pkt_if.checksum_ok <= 1'b0;
        pkt_if.payload     <= '0;
        rx_base     = 4'd0;
        rx_last_ack = 4'd15;
        rx_wlen     = srr_pkg::WLEN_RESET;
        for (int i = 0; i < WIN_SLOTS; i++)
        begin
            rx_slot_vld[i] = 1'b0;
            rx_slot_pay[i] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_core();
        test_window_sizes();
        test_random_traffic();

        wait_idle();
        repeat (20) @(posedge clk);
        $display("%0d packets sent (%0d corrupt); %0d deliveries and %0d ACKs checked",
                 packets_sent, corrupt_sent, deliveries_seen, acks_seen);
        $display("window lengths 0 to 15 incl. saturation, buffered, duplicate and dropped packets");
        if (mismatches == 0 && due_wr == due_rd)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
